### sv/hnc_pkg.sv
// ----------------------------------------------------------------------------
// hnc_pkg
// Shared types and constants for the pixel negative / hsv channel block.
// ----------------------------------------------------------------------------
package hnc_pkg;

  // mode register codes
  localparam logic [2:0] MODE_PASS = 3'd0;
  localparam logic [2:0] MODE_NEG  = 3'd1;
  localparam logic [2:0] MODE_HUE  = 3'd2;
  localparam logic [2:0] MODE_SAT  = 3'd3;
  localparam logic [2:0] MODE_VAL  = 3'd4;

  // register index of mode
  localparam logic REG_MODE = 1'b0;

  localparam int QUO_W = 8;   // quotient bits, one per divider cell
  localparam int REM_W = 16;  // numerator / partial remainder width

  localparam logic [7:0]  CHAN_MAX  = 8'd255;
  localparam logic [15:0] SCALE_MAX = 16'd240;
  localparam logic [15:0] SECTOR    = 16'd40;

  // data handed from cell to cell
  typedef struct packed {
    logic             gray;
    logic [7:0]       blue;
    logic [7:0]       green;
    logic [7:0]       red;
    logic [REM_W-1:0] rem;
    logic [7:0]       dvs;
    logic [QUO_W-1:0] quo;
  } hnc_item_t;

endpackage

### sv/hnc_prep.sv
// ----------------------------------------------------------------------------
// hnc_prep
// Head cell: finds max/min, builds dividend and divisor for the selected
// gray mode and the bypass bytes for pass-through / negative.
// ----------------------------------------------------------------------------
module hnc_prep (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [2:0]         mode,
  input  logic               valid_i,
  input  logic [7:0]         blue_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         red_i,
  output logic               ready_o,
  input  logic               ready_i,
  output logic               valid_o,
  output hnc_pkg::hnc_item_t data_o
);
  import hnc_pkg::*;

  logic       valid_r;
  hnc_item_t  data_r;
  hnc_item_t  data_nxt;

  logic [7:0]  mx;
  logic [7:0]  mn;
  logic [15:0] dw;
  logic [15:0] hue_n;

  // channel max and min
  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx)  mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn)  mn = blue_i;
    dw = {8'd0, mx - mn};
  end

  // hue dividend, already wrapped into 0 .. 240*d-1
  always_comb begin
    if (mx == red_i) begin
      if (green_i >= blue_i) begin
        hue_n = SECTOR * {8'd0, green_i - blue_i};
      end else begin
        hue_n = SCALE_MAX * dw - SECTOR * {8'd0, blue_i - green_i};
      end
    end else if (mx == green_i) begin
      hue_n = (SECTOR * {8'd0, blue_i}) + ((SECTOR << 1) * dw) - (SECTOR * {8'd0, red_i});
    end else begin
      hue_n = (SECTOR * {8'd0, red_i}) + ((SECTOR << 2) * dw) - (SECTOR * {8'd0, green_i});
    end
  end

  // per-mode setup; zero dividend with unit divisor forces a zero result
  always_comb begin
    data_nxt       = '0;
    data_nxt.blue  = blue_i;
    data_nxt.green = green_i;
    data_nxt.red   = red_i;
    data_nxt.dvs   = 8'd1;
    case (mode)
      MODE_NEG: begin
        data_nxt.blue  = CHAN_MAX - blue_i;
        data_nxt.green = CHAN_MAX - green_i;
        data_nxt.red   = CHAN_MAX - red_i;
      end
      MODE_HUE: begin
        data_nxt.gray = 1'b1;
        if (mx != mn) begin
          data_nxt.rem = hue_n;
          data_nxt.dvs = mx - mn;
        end
      end
      MODE_SAT: begin
        data_nxt.gray = 1'b1;
        if (mx != 8'd0) begin
          data_nxt.rem = SCALE_MAX * dw;
          data_nxt.dvs = mx;
        end
      end
      MODE_VAL: begin
        data_nxt.gray = 1'b1;
        data_nxt.rem  = SCALE_MAX * {8'd0, mx};
        data_nxt.dvs  = CHAN_MAX;
      end
      default: begin
        data_nxt.gray = 1'b0;
      end
    endcase
  end

  // stage register, fills whenever empty or draining
  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

### sv/hnc_div_cell.sv
// ----------------------------------------------------------------------------
// hnc_div_cell
// One restoring-division cell: resolves a single quotient bit and passes
// the partial remainder on to its neighbor.
// ----------------------------------------------------------------------------
module hnc_div_cell #(
  parameter int BIT_POS = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_i,
  input  hnc_pkg::hnc_item_t data_i,
  output logic               ready_o,
  input  logic               ready_i,
  output logic               valid_o,
  output hnc_pkg::hnc_item_t data_o
);
  import hnc_pkg::*;

  logic             valid_r;
  hnc_item_t        data_r;
  hnc_item_t        data_nxt;
  logic [REM_W-1:0] dvs_sh;

  // trial subtract of the shifted divisor
  always_comb begin
    dvs_sh   = {{(REM_W-8){1'b0}}, data_i.dvs} << BIT_POS;
    data_nxt = data_i;
    if (data_i.rem >= dvs_sh) begin
      data_nxt.rem          = data_i.rem - dvs_sh;
      data_nxt.quo[BIT_POS] = 1'b1;
    end
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

### sv/pixel_negative_hsv_channel_top.sv
// ----------------------------------------------------------------------------
// pixel_negative_hsv_channel_top
// Per-pixel pass-through, negative, or hue / saturation / value gray image.
//
//   channel  ports                                    direction
//   in       in_valid, in_stall, in_blue/green/red_in  pixel in
//   out      out_valid, out_stall, out_*_out           result bytes out
//   cfg      cfg_psel .. cfg_pready (apb)              mode register
//
// One pixel per cycle while the output is not stalled; one setup cell plus a
// chain of 8 divider cells, one quotient bit each.
// Every cell is its own elastic stage: a stalled output only holds the cells
// that are full, so bubbles upstream still fill and input keeps flowing.
// Synchronous active-low reset clears all cell valid bits and mode to 0.
// ----------------------------------------------------------------------------
module pixel_negative_hsv_channel_top (
  input  logic        clk,
  input  logic        rst_n,
  // pixel input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_blue_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_red_in,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_blue_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_red_out,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import hnc_pkg::*;

  localparam int NCELL = QUO_W;

  logic [2:0] mode_r;

  hnc_item_t        stage_data [0:NCELL];
  logic [NCELL:0]   stage_valid;
  logic [NCELL+1:0] stage_ready;

  // mode register write on the access phase of a transfer
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PASS;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == REG_MODE)) begin
      mode_r <= cfg_pwdata[2:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_MODE) ? {29'd0, mode_r} : 32'd0;

  // setup cell
  hnc_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .mode    (mode_r),
    .valid_i (in_valid),
    .blue_i  (in_blue_in),
    .green_i (in_green_in),
    .red_i   (in_red_in),
    .ready_o (stage_ready[0]),
    .ready_i (stage_ready[1]),
    .valid_o (stage_valid[0]),
    .data_o  (stage_data[0])
  );

  // divider chain, quotient msb first
  for (genvar k = 1; k <= NCELL; k++) begin : g_cell
    hnc_div_cell #(
      .BIT_POS (NCELL - k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (stage_valid[k-1]),
      .data_i  (stage_data[k-1]),
      .ready_o (stage_ready[k]),
      .ready_i (stage_ready[k+1]),
      .valid_o (stage_valid[k]),
      .data_o  (stage_data[k])
    );
  end

  assign stage_ready[NCELL+1] = !out_stall;
  assign in_stall             = !stage_ready[0];

  // last cell is the output register
  assign out_valid     = stage_valid[NCELL];
  assign out_blue_out  = stage_data[NCELL].gray ? stage_data[NCELL].quo
                                                : stage_data[NCELL].blue;
  assign out_green_out = stage_data[NCELL].gray ? stage_data[NCELL].quo
                                                : stage_data[NCELL].green;
  assign out_red_out   = stage_data[NCELL].gray ? stage_data[NCELL].quo
                                                : stage_data[NCELL].red;

endmodule

### tb/sv/tb_pixel_negative_hsv_channel_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pixel_negative_hsv_channel_top
// Self-checking bench for the pixel negative / hsv gray block. Pixels are
// streamed through the valid/stall input channel while the mode register is
// stepped over defined and undefined modes via apb. Each accepted pixel is
// run through a local predictor and the expected bytes are queued; every
// result transfer is checked against the oldest entry. Both channels idle at
// random in three regimes, and the bench checks that no result goes missing.
// ----------------------------------------------------------------------------
module tb_pixel_negative_hsv_channel_top;
  import hnc_pkg::*;

  localparam int PIPE_LAT       = 9;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_ITEMS    = 80;
  localparam int HUE_SPAN       = 240;
  localparam int HUE_SECTOR     = 40;
  localparam int GRAY_FULL      = 240;
  localparam int BYTE_FULL      = 255;

  localparam logic [2:0] ADDR_MODE   = 3'(4 * REG_MODE);
  localparam logic [2:0] ADDR_UNUSED = 3'd4;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_blue_in = 8'd0;
  logic [7:0]  in_green_in = 8'd0;
  logic [7:0]  in_red_in = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_blue_out;
  logic [7:0]  out_green_out;
  logic [7:0]  out_red_out;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // bench state
  pix_t        pixel_q[$];
  pix_t        expected_q[$];
  logic [2:0]  cur_mode = MODE_PASS;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          err_cnt = 0;
  int          quiet_cnt = 0;
  pix_t        want_px;
  pix_t        got_px;

  pixel_negative_hsv_channel_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_blue_in   (in_blue_in),
    .in_green_in  (in_green_in),
    .in_red_in    (in_red_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_blue_out (out_blue_out),
    .out_green_out(out_green_out),
    .out_red_out  (out_red_out),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready)
  );

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expected output bytes for one pixel under a given mode
  function automatic pix_t convert_pixel(logic [2:0] m, pix_t p);
    int   r, g, b, mx, mn, d, n, level;
    pix_t res;
    r = p.red;
    g = p.green;
    b = p.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    level = 0;
    res = p;
    case (m)
      MODE_NEG: begin
        res.blue  = 8'(BYTE_FULL - b);
        res.green = 8'(BYTE_FULL - g);
        res.red   = 8'(BYTE_FULL - r);
      end
      MODE_HUE, MODE_SAT, MODE_VAL: begin
        if (m == MODE_HUE) begin
          // gray pixel has no hue; ties go red, then green, then blue
          if (d != 0) begin
            if (mx == r) n = HUE_SECTOR * (g - b);
            else if (mx == g) n = HUE_SECTOR * (b - r) + 2 * HUE_SECTOR * d;
            else n = HUE_SECTOR * (r - g) + 4 * HUE_SECTOR * d;
            if (n < 0) n = n + HUE_SPAN * d;
            level = (n / d) % HUE_SPAN;
          end
        end else if (m == MODE_SAT) begin
          level = (mx == 0) ? 0 : (GRAY_FULL * d) / mx;
        end else begin
          level = (GRAY_FULL * mx) / BYTE_FULL;
        end
        res.blue  = 8'(level);
        res.green = 8'(level);
        res.red   = 8'(level);
      end
      default: res = p;
    endcase
    return res;
  endfunction

  // random pixel, biased toward gray pixels, ties and saturated channels
  function automatic pix_t rand_pixel();
    pix_t p;
    p.blue  = 8'($urandom());
    p.green = 8'($urandom());
    p.red   = 8'($urandom());
    case ($urandom_range(9))
      0: begin
        p.green = p.blue;
        p.red   = p.blue;
      end
      1: begin
        p.blue  = {8{p.blue[0]}};
        p.green = {8{p.green[0]}};
        p.red   = {8{p.red[0]}};
      end
      2: p.red = p.green;
      3: p.green = p.blue;
      4: p.red = p.blue;
      default: ;
    endcase
    return p;
  endfunction

  // input driver: payload only moves when the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_q.push_back(convert_pixel(cur_mode, {in_blue_in, in_green_in, in_red_in}));
      end
      if (!in_valid || !in_stall) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          got_px = pixel_q.pop_front();
          in_valid    <= 1'b1;
          in_blue_in  <= got_px.blue;
          in_green_in <= got_px.green;
          in_red_in   <= got_px.red;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result, expected none, actual b=%0d g=%0d r=%0d",
                   $time, out_blue_out, out_green_out, out_red_out);
        end else begin
          want_px = expected_q.pop_front();
          if (want_px.blue !== out_blue_out || want_px.green !== out_green_out ||
              want_px.red !== out_red_out) begin
            err_cnt++;
            $display("%0t: mismatch, expected b=%0d g=%0d r=%0d, actual b=%0d g=%0d r=%0d",
                     $time, want_px.blue, want_px.green, want_px.red,
                     out_blue_out, out_green_out, out_red_out);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cnt <= 0;
    else quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // apb write: setup cycle, then access until pready
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == ADDR_MODE) cur_mode = data[2:0];
    @(negedge clk);
  endtask

  // mode write with random upper bits, which the block masks off
  task automatic set_mode(input logic [2:0] m);
    apb_write(ADDR_MODE, ($urandom() & ~32'h7) | 32'(m));
  endtask

  task automatic push_px(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
    pixel_q.push_back('{blue: b, green: g, red: r});
  endtask

  // block until every queued pixel is taken and every result is back
  task automatic wait_drained();
    while (pixel_q.size() != 0 || in_valid || expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic run_random(input logic [2:0] m, input bit hold_mid);
    set_mode(m);
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      pixel_q.push_back(rand_pixel());
      if (hold_mid && k == PHASE_ITEMS / 2) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    int send_tbl[3];
    int recv_tbl[3];
    send_tbl = '{38, 50, 0};
    recv_tbl = '{50, 38, 0};

    // reset
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = send_tbl[0];
    recv_idle_pct = recv_tbl[0];

    // directed: mode after reset is pass-through
    push_px(8'h00, 8'h00, 8'h00);
    push_px(8'hFF, 8'hFF, 8'hFF);
    wait_drained();

    set_mode(MODE_NEG);
    push_px(8'h00, 8'hFF, 8'h55);
    push_px(8'hFF, 8'h00, 8'hAA);
    wait_drained();

    // hue: gray, red max with wrap, red max, red/green tie, green max,
    // blue max, green/blue tie
    set_mode(MODE_HUE);
    push_px(8'd128, 8'd128, 8'd128);
    push_px(8'd10,  8'd0,   8'd255);
    push_px(8'd0,   8'd100, 8'd255);
    push_px(8'd10,  8'd200, 8'd200);
    push_px(8'd50,  8'd255, 8'd0);
    push_px(8'd255, 8'd30,  8'd90);
    push_px(8'd200, 8'd200, 8'd10);
    wait_drained();

    // saturation: black pixel and full range
    set_mode(MODE_SAT);
    push_px(8'd0, 8'd0,   8'd0);
    push_px(8'd0, 8'd0,   8'd255);
    push_px(8'd0, 8'd254, 8'd255);
    wait_drained();

    set_mode(MODE_VAL);
    push_px(8'd0,   8'd0,   8'd0);
    push_px(8'd255, 8'd255, 8'd255);
    push_px(8'd1,   8'd0,   8'd0);
    wait_drained();

    // undefined modes act as pass-through
    set_mode(3'd5);
    push_px(8'd1, 8'd2, 8'd3);
    wait_drained();
    set_mode(3'd7);
    push_px(8'd200, 8'd100, 8'd50);
    wait_drained();

    // write beyond the register map must leave mode alone
    apb_write(ADDR_UNUSED, $urandom() | 32'h1);
    push_px(8'd200, 8'd100, 8'd50);
    wait_drained();

    // random part, three idling regimes
    for (int rg = 0; rg < 3; rg++) begin
      send_idle_pct = send_tbl[rg];
      recv_idle_pct = recv_tbl[rg];
      run_random(MODE_PASS, rg == 0);
      run_random(MODE_HUE, rg == 0);
      run_random(MODE_NEG, 1'b0);
      run_random(MODE_SAT, 1'b0);
      run_random(3'($urandom_range(5, 7)), 1'b0);
      run_random(MODE_VAL, 1'b0);
    end

    // drain, then watch for stray results
    wait_drained();
    repeat (2 * PIPE_LAT) @(posedge clk);
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
